// File: design/line_raster_onebit_writer_unit_defines.svh
// Shared assertion macros for the line rasterizer checker.
`ifndef LINE_RASTER_ONEBIT_WRITER_UNIT_DEFINES_SVH
`define LINE_RASTER_ONEBIT_WRITER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside of the disable condition.
`define LROW_ASSERT_SAME(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LROW_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/lrow_pkg.sv
`default_nettype none

package lrow_pkg;

    localparam int COORD_W  = 14;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int DELTA_W  = COORD_W;
    localparam int ERR_W    = 16;
    localparam int ADDR_W   = 16;
    localparam int COLOR_W  = 16;
    localparam int BIT_W    = 3;

    localparam int WIDTH_W  = 10;
    localparam int HEIGHT_W = 9;
    localparam int ROWB_W   = 7;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 2;

    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 24;

    localparam logic [BIT_W-1:0] BIT_TOP = 3'd7;

    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 10'd320;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 9'd180;

    typedef enum logic {
        MODE_START = 1'b0,
        MODE_TICK  = 1'b1
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CANVAS_WIDTH  = 2'd0,
        CFG_CANVAS_HEIGHT = 2'd1,
        CFG_ROW_BYTES     = 2'd2,
        CFG_ONE_BIT_MODE  = 2'd3
    } t_cfg_index;

endpackage

`default_nettype wire

// File: design/line_raster_onebit_writer_unit.sv
// A tick transfer's pixel write is registered and is offered on the result port in the
// cycle after the transfer is accepted.
// Throughput: one transfer per cycle; a start transfer gives no result. Input is taken
// whenever the single result register is empty or is being drained in the same cycle.
// Reset (synchronous, active low) drops any active line, empties the result register
// and returns the canvas registers to 320 x 180, row bytes 0, one-bit mode off.
`default_nettype none

module line_raster_onebit_writer_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Configuration write port.
    input  wire logic                              i_cfg_we,
    input  wire logic [lrow_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [lrow_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Input stream.
    input  wire logic                              i_s_axis_tvalid,
    output      logic                              o_s_axis_tready,
    // tdata, low to high: start_x[13:0], start_y[27:14], end_x[41:28], end_y[55:42],
    // pen_color[71:56], buffer_base[87:72]
    input  wire logic [lrow_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,
    // tuser: mode (0 start, 1 tick)
    input  wire logic                              i_s_axis_tuser,
    // Result stream.
    output      logic                              o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // tdata, low to high: byte_address[15:0], bit_index[18:16], set_bit[19],
    // write_enable[20], zero padding[23:21]
    output      logic [lrow_pkg::M_TDATA_W-1:0]    o_m_axis_tdata,
    output      logic                              o_m_axis_tlast
);

    localparam int CW = lrow_pkg::COORD_W;
    localparam int DW = lrow_pkg::DIFF_W;
    localparam int LW = lrow_pkg::DELTA_W;
    localparam int EW = lrow_pkg::ERR_W;
    localparam int AW = lrow_pkg::ADDR_W;
    localparam int PW = CW - 1;
    localparam int MW = PW + lrow_pkg::ROWB_W;

    // Configuration registers.
    logic [lrow_pkg::WIDTH_W-1:0]  r_canvas_width;
    logic [lrow_pkg::HEIGHT_W-1:0] r_canvas_height;
    logic [lrow_pkg::ROWB_W-1:0]   r_row_bytes;
    logic                          r_one_bit_mode;

    // Line state.
    logic                 r_active, n_active;
    logic                 r_steep, n_steep;
    logic signed [CW-1:0] r_major_pos, n_major_pos;
    logic signed [CW-1:0] r_major_end, n_major_end;
    logic signed [CW-1:0] r_minor_pos, n_minor_pos;
    logic signed [EW-1:0] r_error_acc, n_error_acc;
    logic [LW-1:0]        r_major_delta, n_major_delta;
    logic [LW-1:0]        r_minor_delta, n_minor_delta;
    logic                 r_minor_step_neg, n_minor_step_neg;
    logic                 r_draw_set, n_draw_set;
    logic [AW-1:0]        r_line_base, n_line_base;

    // Result register.
    logic                 r_out_valid, n_out_valid;
    logic [AW-1:0]        r_out_addr, n_out_addr;
    logic [lrow_pkg::BIT_W-1:0] r_out_bit, n_out_bit;
    logic                 r_out_set, n_out_set;
    logic                 r_out_we, n_out_we;
    logic                 r_out_last, n_out_last;

    logic accept;
    logic is_start;
    logic is_tick;

    // Start decode.
    logic signed [CW-1:0] x0, y0, x1, y1;
    logic signed [DW-1:0] dx, dy, adx_w, ady_w, maj_diff, min_diff;
    logic [LW-1:0]        adx, ady;
    logic                 steep, swap;
    logic signed [CW-1:0] maj_a, maj_b, min_a, min_b;

    // Tick datapath.
    logic signed [CW-1:0] px, py;
    logic                 pix_we;
    logic                 pix_last;
    logic [MW-1:0]        row_off;
    logic signed [EW-1:0] err_sub;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign is_start = accept && (lrow_pkg::t_mode'(i_s_axis_tuser) == lrow_pkg::MODE_START);
    assign is_tick  = accept && (lrow_pkg::t_mode'(i_s_axis_tuser) == lrow_pkg::MODE_TICK);

    always_comb begin
        x0 = i_s_axis_tdata[13:0];
        y0 = i_s_axis_tdata[27:14];
        x1 = i_s_axis_tdata[41:28];
        y1 = i_s_axis_tdata[55:42];
        dx = DW'(x1) - DW'(x0);
        dy = DW'(y1) - DW'(y0);
        adx_w = dx[DW-1] ? -dx : dx;
        ady_w = dy[DW-1] ? -dy : dy;
        adx = adx_w[LW-1:0];
        ady = ady_w[LW-1:0];
        steep = ady > adx;
        maj_diff = steep ? dy : dx;
        min_diff = steep ? dx : dy;
        maj_a = steep ? y0 : x0;
        maj_b = steep ? y1 : x1;
        min_a = steep ? x0 : y0;
        min_b = steep ? x1 : y1;
        // A falling major coordinate means the endpoints trade places.
        swap = maj_diff[DW-1];
    end

    always_comb begin
        px = r_steep ? r_minor_pos : r_major_pos;
        py = r_steep ? r_major_pos : r_minor_pos;
        pix_we = !px[CW-1] && !py[CW-1]
              && (px[PW-1:0] < PW'(r_canvas_width))
              && (py[PW-1:0] < PW'(r_canvas_height))
              && r_one_bit_mode;
        pix_last = r_major_pos >= r_major_end;
        row_off = MW'(py[PW-1:0]) * MW'(r_row_bytes);
        err_sub = r_error_acc - EW'(r_minor_delta);
    end

    always_comb begin
        n_active         = r_active;
        n_steep          = r_steep;
        n_major_pos      = r_major_pos;
        n_major_end      = r_major_end;
        n_minor_pos      = r_minor_pos;
        n_error_acc      = r_error_acc;
        n_major_delta    = r_major_delta;
        n_minor_delta    = r_minor_delta;
        n_minor_step_neg = r_minor_step_neg;
        n_draw_set       = r_draw_set;
        n_line_base      = r_line_base;

        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_addr  = r_out_addr;
        n_out_bit   = r_out_bit;
        n_out_set   = r_out_set;
        n_out_we    = r_out_we;
        n_out_last  = r_out_last;

        if (is_start) begin
            n_active         = 1'b1;
            n_steep          = steep;
            n_major_pos      = swap ? maj_b : maj_a;
            n_major_end      = swap ? maj_a : maj_b;
            n_minor_pos      = swap ? min_b : min_a;
            n_major_delta    = steep ? ady : adx;
            n_minor_delta    = steep ? adx : ady;
            n_error_acc      = EW'((steep ? ady : adx) >> 1);
            n_minor_step_neg = swap ? !min_diff[DW-1]
                                    : (min_diff[DW-1] || (min_diff == '0));
            n_draw_set       = i_s_axis_tdata[71:56] != '0;
            n_line_base      = i_s_axis_tdata[87:72];
        end else if (is_tick && r_active) begin
            n_out_valid = 1'b1;
            n_out_we    = pix_we;
            n_out_set   = r_draw_set;
            n_out_last  = pix_last;
            if (pix_we) begin
                n_out_addr = r_line_base + row_off[AW-1:0] + AW'(px[PW-1:3]);
                n_out_bit  = lrow_pkg::BIT_TOP - px[2:0];
            end else begin
                n_out_addr = '0;
                n_out_bit  = '0;
            end
            if (err_sub < 0) begin
                n_minor_pos = r_minor_step_neg ? r_minor_pos - CW'(1) : r_minor_pos + CW'(1);
                n_error_acc = err_sub + EW'(r_major_delta);
            end else begin
                n_error_acc = err_sub;
            end
            if (pix_last) begin
                n_active = 1'b0;
            end else begin
                n_major_pos = r_major_pos + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canvas_width  <= lrow_pkg::WIDTH_RST;
            r_canvas_height <= lrow_pkg::HEIGHT_RST;
            r_row_bytes     <= '0;
            r_one_bit_mode  <= 1'b0;
        end else if (i_cfg_we) begin
            case (lrow_pkg::t_cfg_index'(i_cfg_index))
                lrow_pkg::CFG_CANVAS_WIDTH: begin
                    r_canvas_width <= i_cfg_data[lrow_pkg::WIDTH_W-1:0];
                end
                lrow_pkg::CFG_CANVAS_HEIGHT: begin
                    r_canvas_height <= i_cfg_data[lrow_pkg::HEIGHT_W-1:0];
                end
                lrow_pkg::CFG_ROW_BYTES: begin
                    r_row_bytes <= i_cfg_data[lrow_pkg::ROWB_W-1:0];
                end
                lrow_pkg::CFG_ONE_BIT_MODE: begin
                    r_one_bit_mode <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_steep          <= n_steep;
        r_major_pos      <= n_major_pos;
        r_major_end      <= n_major_end;
        r_minor_pos      <= n_minor_pos;
        r_error_acc      <= n_error_acc;
        r_major_delta    <= n_major_delta;
        r_minor_delta    <= n_minor_delta;
        r_minor_step_neg <= n_minor_step_neg;
        r_draw_set       <= n_draw_set;
        r_line_base      <= n_line_base;
        r_out_addr       <= n_out_addr;
        r_out_bit        <= n_out_bit;
        r_out_set        <= n_out_set;
        r_out_we         <= n_out_we;
        r_out_last       <= n_out_last;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {3'b000, r_out_we, r_out_set, r_out_bit, r_out_addr};

endmodule

`default_nettype wire

// File: design/lrow_checker.sv
`default_nettype none

`include "line_raster_onebit_writer_unit_defines.svh"

module lrow_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_s_axis_tvalid,
    input wire logic                           o_s_axis_tready,
    input wire logic                           i_s_axis_tuser,
    input wire logic                           o_m_axis_tvalid,
    input wire logic                           i_m_axis_tready,
    input wire logic [lrow_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    input wire logic                           o_m_axis_tlast
);

    logic start_xfer;

    assign start_xfer = i_s_axis_tvalid && o_s_axis_tready
                     && (lrow_pkg::t_mode'(i_s_axis_tuser) == lrow_pkg::MODE_START);

    // Reset always leaves the result port empty.
    `LROW_ASSERT_NEXT(a_reset_empties, i_clk, 1'b0, !i_rst_n, !o_m_axis_tvalid, "result valid after reset")

    // An empty result register never blocks the input side.
    `LROW_ASSERT_SAME(a_ready_when_empty, i_clk, !i_rst_n, !o_m_axis_tvalid, o_s_axis_tready, "input stalled with empty result register")

    // A start transfer creates no result of its own.
    `LROW_ASSERT_NEXT(a_start_no_result, i_clk, !i_rst_n, start_xfer, o_m_axis_tvalid == $past(o_m_axis_tvalid && !i_m_axis_tready), "start transfer produced a result")

    // A stalled result holds its contents.
    `LROW_ASSERT_NEXT(a_result_holds, i_clk, !i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast), "stalled result changed")

endmodule

bind line_raster_onebit_writer_unit lrow_checker u_lrow_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

`default_nettype wire

// File: sim/line_raster_onebit_writer_checker.sv
`default_nettype none

module line_raster_onebit_writer_checker
    import lrow_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                    i_in_valid,
    input  wire logic                    i_in_ready,
    // start_x, start_y, end_x, end_y, pen_color, buffer_base from the lowest bit up
    input  wire logic [S_TDATA_W-1:0]    i_in_data,
    // mode
    input  wire logic                    i_in_user,
    input  wire logic                    i_out_valid,
    input  wire logic                    i_out_ready,
    // byte_address, bit_index, set_bit, write_enable, padding from the lowest bit up
    input  wire logic [M_TDATA_W-1:0]    i_out_data,
    input  wire logic                    i_out_last,
    output int                           o_fail_count,
    output int                           o_pending
);

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [BIT_W-1:0]  bit_idx;
        logic              set_bit;
        logic              wr_en;
        logic              last;
    } pixel_write_t;

    pixel_write_t pixel_writes_q[$];

    // Canvas registers as the block should hold them.
    logic [WIDTH_W-1:0]  cv_width;
    logic [HEIGHT_W-1:0] cv_height;
    logic [ROWB_W-1:0]   row_stride;
    logic                onebit_on;

    // Line walker state.
    logic line_on, is_steep, min_dec, pen_on;
    int   maj_pos, maj_end, min_pos, err, maj_delta, min_delta;
    logic [ADDR_W-1:0] base_addr;

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    function automatic int iabs(input int v);
        return (v < 0) ? -v : v;
    endfunction

    task automatic load_line(input logic [S_TDATA_W-1:0] d);
        int x0, y0, x1, y1, t;
        x0 = int'($signed(d[13:0]));
        y0 = int'($signed(d[27:14]));
        x1 = int'($signed(d[41:28]));
        y1 = int'($signed(d[55:42]));
        is_steep = iabs(y1 - y0) > iabs(x1 - x0);
        if (is_steep) begin
            t = x0; x0 = y0; y0 = t;
            t = x1; x1 = y1; y1 = t;
        end
        if (x0 > x1) begin
            t = x0; x0 = x1; x1 = t;
            t = y0; y0 = y1; y1 = t;
        end
        maj_pos   = x0;
        maj_end   = x1;
        min_pos   = y0;
        maj_delta = x1 - x0;
        min_delta = iabs(y1 - y0);
        err       = maj_delta / 2;
        min_dec   = !(y0 < y1);
        pen_on    = d[71:56] != '0;
        base_addr = d[87:72];
        line_on   = 1'b1;
    endtask

    // Emits the pixel at the current position and, short of the line end, steps the major axis.
    task automatic plot_next(output pixel_write_t w);
        int px, py, a;
        px = is_steep ? min_pos : maj_pos;
        py = is_steep ? maj_pos : min_pos;
        w = '0;
        w.wr_en = px >= 0 && py >= 0 && px < int'(cv_width) && py < int'(cv_height)
                  && onebit_on;
        if (w.wr_en) begin
            a = int'(base_addr) + py * int'(row_stride) + (px >> 3);
            w.addr = a[ADDR_W-1:0];
            w.bit_idx = BIT_TOP - px[BIT_W-1:0];
        end
        w.set_bit = pen_on;
        w.last = maj_pos >= maj_end;
        err = err - min_delta;
        if (err < 0) begin
            min_pos = min_pos + (min_dec ? -1 : 1);
            err = err + maj_delta;
        end
        if (w.last) begin
            line_on = 1'b0;
        end else begin
            maj_pos = maj_pos + 1;
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        pixel_write_t w;
        if (!i_rst_n) begin
            cv_width      = WIDTH_RST;
            cv_height     = HEIGHT_RST;
            row_stride    = '0;
            onebit_on     = 1'b0;
            line_on       = 1'b0;
            is_steep      = 1'b0;
            min_dec       = 1'b0;
            pen_on        = 1'b0;
            maj_pos = 0; maj_end = 0; min_pos = 0; err = 0; maj_delta = 0; min_delta = 0;
            base_addr     = '0;
            pixel_writes_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_CANVAS_WIDTH:  cv_width = i_cfg_data[WIDTH_W-1:0];
                    CFG_CANVAS_HEIGHT: cv_height = i_cfg_data[HEIGHT_W-1:0];
                    CFG_ROW_BYTES:     row_stride = i_cfg_data[ROWB_W-1:0];
                    CFG_ONE_BIT_MODE:  onebit_on = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (pixel_writes_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got tdata %h last %b",
                             $time, i_out_data, i_out_last);
                    o_fail_count++;
                end else begin
                    w = pixel_writes_q.pop_front();
                    check_field("byte_address", w.addr, i_out_data[15:0]);
                    check_field("bit_index", w.bit_idx, i_out_data[18:16]);
                    check_field("set_bit", w.set_bit, i_out_data[19]);
                    check_field("write_enable", w.wr_en, i_out_data[20]);
                    check_field("last", w.last, i_out_last);
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (t_mode'(i_in_user) == MODE_START) begin
                    load_line(i_in_data);
                end else if (line_on) begin
                    plot_next(w);
                    pixel_writes_q.push_back(w);
                end
            end
        end
        o_pending = pixel_writes_q.size();
    end

endmodule

`default_nettype wire

// File: sim/tb_line_raster_onebit_writer_unit.sv
`default_nettype none

module tb_line_raster_onebit_writer_unit;
    import lrow_pkg::*;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    // start_x, start_y, end_x, end_y, pen_color, buffer_base from the lowest bit up
    logic [S_TDATA_W-1:0]   i_s_axis_tdata = '0;
    // mode
    logic                   i_s_axis_tuser = 1'b0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    // byte_address, bit_index, set_bit, write_enable, padding from the lowest bit up
    logic [M_TDATA_W-1:0]   o_m_axis_tdata;
    logic                   o_m_axis_tlast;

    int fail_count;
    int pending;
    int counted = 0;
    logic src_calm = 1'b0;
    logic sink_calm = 1'b0;
    int sink_wait = 0;

    always #6 i_clk = ~i_clk;

    line_raster_onebit_writer_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    line_raster_onebit_writer_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_s_axis_tvalid),
        .i_in_ready   (o_s_axis_tready),
        .i_in_data    (i_s_axis_tdata),
        .i_in_user    (i_s_axis_tuser),
        .i_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .i_out_data   (o_m_axis_tdata),
        .i_out_last   (o_m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Result side: a fresh random stall after each transfer, none in calm stretches.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            sink_wait = 0;
        end else if (o_m_axis_tvalid && i_m_axis_tready) begin
            if ($urandom_range(0, 31) == 0) sink_calm = !sink_calm;
            sink_wait = sink_calm ? 0 : $urandom_range(0, 7);
            i_m_axis_tready <= (sink_wait == 0);
        end else if (!i_m_axis_tready) begin
            if (sink_wait > 0) sink_wait--;
            if (sink_wait == 0) i_m_axis_tready <= 1'b1;
        end
    end

    // Called at a rising edge; returns at the edge where the transfer happened, valid still high.
    task automatic send(input t_mode m, input logic [S_TDATA_W-1:0] d);
        int gap;
        gap = src_calm ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser <= m;
        i_s_axis_tdata <= d;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // Start transfer for a line, then a number of tick transfers with random payload.
    task automatic draw_line(input int sx, input int sy, input int ex, input int ey,
                             input logic [COLOR_W-1:0] color, input logic [ADDR_W-1:0] base,
                             input int ticks);
        int ax, ay, len;
        logic [13:0] sx14, sy14, ex14, ey14;
        ax = (ex > sx) ? ex - sx : sx - ex;
        ay = (ey > sy) ? ey - sy : sy - ey;
        len = ((ax > ay) ? ax : ay) + 1;
        sx14 = sx[13:0]; sy14 = sy[13:0]; ex14 = ex[13:0]; ey14 = ey[13:0];
        send(MODE_START, {base, color, ey14, ex14, sy14, sx14});
        repeat (ticks) send(MODE_TICK, S_TDATA_W'({$urandom, $urandom, $urandom}));
        counted += 1 + ((ticks < len) ? ticks : len);
    endtask

    // Waits until every expected pixel write has arrived, then writes all four registers.
    task automatic configure(input int w, input int h, input int rb, input int om);
        i_s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_CANVAS_WIDTH;
        i_cfg_data <= 10'(w);
        @(posedge i_clk);
        i_cfg_index <= CFG_CANVAS_HEIGHT;
        i_cfg_data <= 10'(h);
        @(posedge i_clk);
        i_cfg_index <= CFG_ROW_BYTES;
        i_cfg_data <= 10'(rb);
        @(posedge i_clk);
        i_cfg_index <= CFG_ONE_BIT_MODE;
        i_cfg_data <= 10'(om);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly complete short lines around the canvas; some cut short, some with extra
    // ticks after the end, and some full-range lines dropped after a few pixels.
    task automatic random_lines(input int goal);
        int kind, cx, cy, span, sx, sy, ex, ey, len, ticks;
        logic [COLOR_W-1:0] color;
        while (counted < goal) begin
            if ($urandom_range(0, 15) == 0) src_calm = !src_calm;
            kind = $urandom_range(0, 9);
            color = ($urandom_range(0, 3) == 0) ? '0 : COLOR_W'($urandom_range(1, 65535));
            if (kind == 0) begin
                draw_line($urandom_range(0, 16383) - 8192, $urandom_range(0, 16383) - 8192,
                          $urandom_range(0, 16383) - 8192, $urandom_range(0, 16383) - 8192,
                          color, ADDR_W'($urandom), $urandom_range(0, 3));
            end else begin
                cx = $urandom_range(0, 700) - 30;
                cy = $urandom_range(0, 540) - 30;
                span = ($urandom_range(0, 7) == 0) ? 60 : 10;
                sx = cx + $urandom_range(0, 2 * span) - span;
                sy = cy + $urandom_range(0, 2 * span) - span;
                ex = cx + $urandom_range(0, 2 * span) - span;
                ey = cy + $urandom_range(0, 2 * span) - span;
                len = ((ex > sx ? ex - sx : sx - ex) > (ey > sy ? ey - sy : sy - ey) ?
                       (ex > sx ? ex - sx : sx - ex) : (ey > sy ? ey - sy : sy - ey)) + 1;
                if (kind == 1) begin
                    ticks = $urandom_range(0, len - 1);
                end else begin
                    ticks = len + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
                end
                draw_line(sx, sy, ex, ey, color, ADDR_W'($urandom), ticks);
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        configure(640, 480, 80, 1);
        // Single pixel at the origin, then a tick with no line left.
        draw_line(0, 0, 0, 0, 16'hFFFF, 16'h0000, 2);
        // Extreme diagonal, replaced by a new line after two pixels.
        draw_line(-8192, -8192, 8191, 8191, 16'h0000, 16'hFFFF, 2);
        // Crosses the right edge on the last row; the address wraps past 65535.
        draw_line(637, 479, 641, 479, 16'h8000, 16'hFFF0, 5);
        // Steep line walking back toward negative y.
        draw_line(3, 2, 1, -1, 16'h0001, 16'h1234, 4);
        draw_line(8191, -8192, -8192, 8191, 16'h00FF, 16'hABCD, 1);
        // Single pixel off the canvas.
        draw_line(-1, -1, -1, -1, 16'h0000, 16'h0001, 1);

        random_lines(counted + 190);
        configure(1, 1, 0, 1);
        random_lines(counted + 190);
        configure(320, 180, 40, 1);
        random_lines(counted + 190);
        configure(1023, 511, 127, 1);
        random_lines(counted + 190);
        configure(0, 0, 0, 1);
        random_lines(counted + 190);
        configure(640, 480, 80, 0);
        random_lines(counted + 190);
        // Full-width data words, so the bits above each register are dropped.
        configure($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023),
                  $urandom_range(0, 1023) | 1);
        random_lines(counted + 190);
        configure($urandom_range(16, 200), $urandom_range(16, 200), $urandom_range(0, 80), 1);
        random_lines(counted + 190);

        i_s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #6000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
